// ===== src/plsw_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window limiter package
// Shared types and constants for the per-user sliding window rate limiter.
// ----------------------------------------------------------------------------
package plsw_pkg;

	localparam int LOG_DEPTH_DEF = 64;

	localparam int USER_W  = 16;
	localparam int TIME_W  = 32;
	localparam int COUNT_W = 7;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd1;

	localparam logic [COUNT_W-1:0] MAX_REQUESTS_RST  = 7'd3;
	localparam logic [TIME_W-1:0]  WINDOW_LENGTH_RST = 32'd10;
	localparam logic [COUNT_W-1:0] COUNT_SAT         = 7'd127;

	// One log entry as stored in the log memory.
	typedef struct packed {
		logic              valid;
		logic [USER_W-1:0] user;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	// Verdict of the entry evaluation unit on one log entry.
	typedef struct packed {
		logic expire;
		logic live;
		logic match;
	} eval_t;

endpackage

// ===== src/plsw_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one rate limit request per beat.
// ----------------------------------------------------------------------------
interface plsw_req_if;
	logic                         valid;
	logic                         ready;
	logic [plsw_pkg::USER_W-1:0]  user_id;
	logic [plsw_pkg::TIME_W-1:0]  request_time;

	modport source (output valid, output user_id, output request_time, input ready);
	modport sink (input valid, input user_id, input request_time, output ready);
endinterface

// ===== src/plsw_resp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one limiter decision per beat.
// ----------------------------------------------------------------------------
interface plsw_resp_if;
	logic                          valid;
	logic                          ready;
	logic                          allowed;
	logic [plsw_pkg::COUNT_W-1:0]  user_count;
	logic                          log_full;

	modport source (output valid, output allowed, output user_count, output log_full,
		input ready);
	modport sink (input valid, input allowed, input user_count, input log_full,
		output ready);
endinterface

// ===== src/plsw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module plsw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/plsw_eval.sv =====
// ----------------------------------------------------------------------------
// Entry evaluation unit
// Ages one log entry against the request, flags expiry and a user match,
// and advances the saturating match count.
// ----------------------------------------------------------------------------
module plsw_eval (
	input  plsw_pkg::entry_t             entry,
	input  logic [plsw_pkg::USER_W-1:0]  user_id,
	input  logic [plsw_pkg::TIME_W-1:0]  now,
	input  logic [plsw_pkg::TIME_W-1:0]  window_length,
	input  logic [plsw_pkg::COUNT_W-1:0] count_in,
	output plsw_pkg::eval_t              verdict,
	output logic [plsw_pkg::COUNT_W-1:0] count_out
);

	logic [plsw_pkg::TIME_W-1:0] age;

	// Ages wrap modulo 2^32, so an entry stamped after the request looks old.
	assign age = now - entry.stamp;

	always_comb begin
		verdict.expire = entry.valid && (age >= window_length);
		verdict.live   = entry.valid && !verdict.expire;
		verdict.match  = verdict.live && (entry.user == user_id);
		count_out      = count_in;
		if (verdict.match && (count_in != plsw_pkg::COUNT_SAT)) begin
			count_out = count_in + plsw_pkg::COUNT_W'(1);
		end
	end

endmodule

// ===== src/per_user_sliding_window_limiter_core.sv =====
// ----------------------------------------------------------------------------
// Per-user sliding window limiter
// Keeps a log of allowed requests; each request expires old entries, counts
// the user's live entries and is allowed and logged when under the limit.
//
//   channel   dir  beat contents
//   req       in   user_id, request_time
//   resp      out  allowed, user_count, log_full
//   cfg_*     in   write enable, register index, write data (no handshake)
//
// The sequencer walks the log memory one entry per cycle through the single
// read port and the shared entry evaluation unit, drains the registered read
// data, then decides and writes the new entry.
// The response is registered in the decision step, and the next request beat
// can be taken once the response is valid.
// After reset the log memory is cleared one entry per cycle, during which
// req.ready stays low.
// The response sits in an output register; a new request is taken while it
// waits, and the decision step holds until that register is free.
// ----------------------------------------------------------------------------
module per_user_sliding_window_limiter_core #(
	parameter int LOG_DEPTH = plsw_pkg::LOG_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	plsw_req_if.sink                       req,
	plsw_resp_if.source                    resp,
	input  logic                           cfg_we,
	input  logic [plsw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [plsw_pkg::CFG_W-1:0]     cfg_data
);

	localparam int ADDR_W = $clog2(LOG_DEPTH);
	localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LOG_DEPTH);
	localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(LOG_DEPTH - 1);
	localparam int ENTRY_W = $bits(plsw_pkg::entry_t);

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_DECIDE = 2'd3;

	logic [1:0]                      state_q;
	logic [CNT_W-1:0]                idx_q;
	logic                            eval_vld_s1;
	logic [ADDR_W-1:0]               eval_idx_s1;
	logic [plsw_pkg::COUNT_W-1:0]    count_q;
	logic                            free_found_q;
	logic [ADDR_W-1:0]               free_idx_q;
	logic [plsw_pkg::USER_W-1:0]     uid_q;
	logic [plsw_pkg::TIME_W-1:0]     now_q;
	logic [plsw_pkg::COUNT_W-1:0]    max_q;
	logic [plsw_pkg::TIME_W-1:0]     window_q;

	logic                            resp_valid_q;
	logic                            resp_allowed_q;
	logic [plsw_pkg::COUNT_W-1:0]    resp_count_q;
	logic                            resp_full_q;

	logic                            ram_we;
	logic [ADDR_W-1:0]               ram_waddr;
	plsw_pkg::entry_t                ram_wentry;
	logic                            ram_re;
	logic [ENTRY_W-1:0]              ram_rdata;
	plsw_pkg::entry_t                rd_entry;

	plsw_pkg::eval_t                 verdict;
	logic [plsw_pkg::COUNT_W-1:0]    count_next;

	logic                            under_limit;
	logic                            allow;
	logic                            out_free;
	logic                            req_fire;

	assign rd_entry    = plsw_pkg::entry_t'(ram_rdata);
	assign under_limit = count_q < max_q;
	assign allow       = under_limit && free_found_q;
	assign out_free    = !resp_valid_q || resp.ready;
	assign req.ready   = (state_q == ST_IDLE);
	assign req_fire    = req.valid && req.ready;

	assign resp.valid      = resp_valid_q;
	assign resp.allowed    = resp_allowed_q;
	assign resp.user_count = resp_count_q;
	assign resp.log_full   = resp_full_q;

	plsw_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (LOG_DEPTH)
	) u_log (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wentry),
		.re    (ram_re),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	plsw_eval u_eval (
		.entry         (rd_entry),
		.user_id       (uid_q),
		.now           (now_q),
		.window_length (window_q),
		.count_in      (count_q),
		.verdict       (verdict),
		.count_out     (count_next)
	);

	// Log memory write port: clearing pass, expiry write-back, insertion.
	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = eval_idx_s1;
		ram_wentry = rd_entry;
		ram_re     = (state_q == ST_SCAN) && (idx_q != DEPTH_C);
		unique case (state_q)
			ST_CLEAR: begin
				ram_we     = 1'b1;
				ram_waddr  = idx_q[ADDR_W-1:0];
				ram_wentry = '0;
			end
			ST_SCAN: begin
				ram_we           = eval_vld_s1 && verdict.expire;
				ram_wentry.valid = 1'b0;
			end
			ST_DECIDE: begin
				ram_we           = allow;
				ram_waddr        = free_idx_q;
				ram_wentry.valid = 1'b1;
				ram_wentry.user  = uid_q;
				ram_wentry.stamp = now_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= plsw_pkg::MAX_REQUESTS_RST;
			window_q <= plsw_pkg::WINDOW_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				plsw_pkg::REG_MAX_REQUESTS:  max_q <= cfg_data[plsw_pkg::COUNT_W-1:0];
				plsw_pkg::REG_WINDOW_LENGTH: window_q <= cfg_data[plsw_pkg::TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			idx_q        <= '0;
			eval_vld_s1  <= 1'b0;
			resp_valid_q <= 1'b0;
		end else begin
			eval_vld_s1 <= ram_re;
			if (resp_valid_q && resp.ready) begin
				resp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_q + CNT_W'(1);
					if (idx_q == LAST_C) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					idx_q <= '0;
					if (req_fire) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q != DEPTH_C) begin
						idx_q <= idx_q + CNT_W'(1);
					end else if (!eval_vld_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (out_free) begin
						resp_valid_q <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request payload, running count, free slot search and response register.
	always_ff @(posedge clk) begin
		eval_idx_s1 <= idx_q[ADDR_W-1:0];
		if (req_fire) begin
			uid_q        <= req.user_id;
			now_q        <= req.request_time;
			count_q      <= '0;
			free_found_q <= 1'b0;
		end
		if ((state_q == ST_SCAN) && eval_vld_s1) begin
			count_q <= count_next;
			if (!verdict.live && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= eval_idx_s1;
			end
		end
		if ((state_q == ST_DECIDE) && out_free) begin
			resp_allowed_q <= allow;
			resp_count_q   <= count_q;
			resp_full_q    <= under_limit && !free_found_q;
		end
	end

endmodule

// ===== dv/per_user_sliding_window_limiter_core_tb.sv =====
// ----------------------------------------------------------------------------
// Sliding window limiter testbench
// Drives requests into the limiter core at random pace and checks every
// decision against a local model of the request log. A short directed run
// covers the default limits, expiry at the window edge, wrapped timestamps,
// zero window and zero limit. Random phases then sweep the limits, user
// pools and time steps: a saturated user, a filled log and noisy timestamps.
// ----------------------------------------------------------------------------
module per_user_sliding_window_limiter_core_tb;

	localparam int USER_W     = plsw_pkg::USER_W;
	localparam int TIME_W     = plsw_pkg::TIME_W;
	localparam int COUNT_W    = plsw_pkg::COUNT_W;
	localparam int CFG_W      = plsw_pkg::CFG_W;
	localparam int CFG_IDX_W  = plsw_pkg::CFG_IDX_W;
	localparam int DEPTH      = plsw_pkg::LOG_DEPTH_DEF;
	localparam int IDLE_LIMIT = 4000;
	localparam int LONG_HOLD  = 300;

	typedef struct packed {
		logic               allowed;
		logic [COUNT_W-1:0] user_count;
		logic               log_full;
	} verdict_t;

	class limiter_scoreboard;
		bit               live[DEPTH];
		bit [USER_W-1:0]  owner[DEPTH];
		bit [TIME_W-1:0]  stamp[DEPTH];
		bit [COUNT_W-1:0] req_limit;
		bit [TIME_W-1:0]  window_length;
		verdict_t         pending_verdicts[$];
		int               errors;

		function void clear();
			foreach (live[i]) live[i] = 1'b0;
			req_limit     = plsw_pkg::MAX_REQUESTS_RST;
			window_length = plsw_pkg::WINDOW_LENGTH_RST;
			pending_verdicts.delete();
			errors = 0;
		endfunction

		function int pending();
			return pending_verdicts.size();
		endfunction

		task report_mismatch(input string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// Expire, count the user's live entries, then decide and log.
		function void note_request(input bit [USER_W-1:0] uid, input bit [TIME_W-1:0] now);
			int unsigned count;
			int slot;
			bit [TIME_W-1:0] age;
			verdict_t v;
			count = 0;
			slot = -1;
			for (int i = 0; i < DEPTH; i++) begin
				if (live[i]) begin
					age = now - stamp[i];
					if (age >= window_length)
						live[i] = 1'b0;
					else if (owner[i] == uid && count < plsw_pkg::COUNT_SAT)
						count++;
				end
				if (!live[i] && slot < 0)
					slot = i;
			end
			v.allowed = 1'b0;
			v.user_count = count[COUNT_W-1:0];
			v.log_full = 1'b0;
			if (count < req_limit) begin
				if (slot < 0) begin
					v.log_full = 1'b1;
				end else begin
					live[slot] = 1'b1;
					owner[slot] = uid;
					stamp[slot] = now;
					v.allowed = 1'b1;
				end
			end
			pending_verdicts.insert(pending_verdicts.size(), v);
		endfunction

		task check_response(input verdict_t got);
			verdict_t want;
			if (pending_verdicts.size() == 0) begin
				report_mismatch("response beat with no request outstanding");
				return;
			end
			want = pending_verdicts.pop_front();
			if (got.allowed !== want.allowed)
				report_mismatch($sformatf("allowed %b, expected %b", got.allowed, want.allowed));
			if (got.user_count !== want.user_count)
				report_mismatch($sformatf("user_count %0d, expected %0d",
					got.user_count, want.user_count));
			if (got.log_full !== want.log_full)
				report_mismatch($sformatf("log_full %b, expected %b", got.log_full, want.log_full));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	plsw_req_if  req();
	plsw_resp_if resp();

	limiter_scoreboard decisions;
	int                idle_cycles;

	per_user_sliding_window_limiter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.resp      (resp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Monitor and watchdog: a cycle with no beat on either channel counts
	// toward the limit.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				decisions.note_request(req.user_id, req.request_time);
			if (resp.valid && resp.ready)
				decisions.check_response({resp.allowed, resp.user_count, resp.log_full});
			if ((req.valid && req.ready) || (resp.valid && resp.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("[FAIL] regression broken");
					$finish;
				end
			end
		end
	end

	// Response side back-pressure. Calm stretches alternate with choppy ones,
	// and two long holds let the block back up into its request port.
	int  sink_stall;
	int  sink_beats;
	int  sink_cycles;
	bit  sink_calm;
	bit  hold_first_done;
	bit  hold_second_done;
	int  sink_pick;

	always @(posedge clk) begin
		if (!arst_n) begin
			resp.ready <= 1'b0;
			sink_stall = 0;
			sink_beats = 0;
			sink_cycles = 0;
			sink_calm = 1'b0;
			hold_first_done = 1'b0;
			hold_second_done = 1'b0;
		end else begin
			if (resp.valid && resp.ready)
				sink_beats++;
			sink_cycles++;
			if (sink_cycles % 2000 == 0)
				sink_calm = !sink_calm;
			if (sink_stall > 0) begin
				sink_stall--;
				resp.ready <= 1'b0;
			end else if (!hold_first_done && sink_beats >= 300) begin
				hold_first_done = 1'b1;
				sink_stall = LONG_HOLD;
				resp.ready <= 1'b0;
			end else if (!hold_second_done && sink_beats >= 900) begin
				hold_second_done = 1'b1;
				sink_stall = LONG_HOLD;
				resp.ready <= 1'b0;
			end else if (sink_calm) begin
				resp.ready <= 1'b1;
			end else begin
				sink_pick = $urandom_range(0, 99);
				if (sink_pick < 70) begin
					resp.ready <= 1'b1;
				end else if (sink_pick < 95) begin
					resp.ready <= 1'b0;
					sink_stall = $urandom_range(0, 3);
				end else begin
					resp.ready <= 1'b0;
					sink_stall = $urandom_range(10, 120);
				end
			end
		end
	end

	task automatic send_request(input logic [USER_W-1:0] uid, input logic [TIME_W-1:0] now);
		int gap;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			gap = 0;
		else if (pick < 90)
			gap = $urandom_range(1, 6);
		else
			gap = $urandom_range(20, 150);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.user_id <= uid;
		req.request_time <= now;
		do @(posedge clk); while (!req.ready);
	endtask

	// Stop offering and wait until every decision is back and the
	// sequencer has had time to finish its walk. The first edge lets the
	// monitor log the last request beat before the count is looked at.
	task automatic wait_quiet();
		req.valid <= 1'b0;
		@(posedge clk);
		while (decisions.pending() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
	endtask

	// Both registers are written back to back; the limit word carries random
	// junk above its seven bits.
	task automatic set_limits(input bit [COUNT_W-1:0] max_req, input bit [TIME_W-1:0] window);
		cfg_we <= 1'b1;
		cfg_index <= plsw_pkg::REG_MAX_REQUESTS;
		cfg_data <= ($urandom & ~32'h7F) | CFG_W'(max_req);
		decisions.req_limit = max_req;
		@(posedge clk);
		cfg_index <= plsw_pkg::REG_WINDOW_LENGTH;
		cfg_data <= window;
		decisions.window_length = window;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input bit [COUNT_W-1:0] max_req, input bit [TIME_W-1:0] window,
		input int users, input int unsigned step_max, input int count);
		bit [TIME_W-1:0] now;
		bit [USER_W-1:0] base;
		wait_quiet();
		set_limits(max_req, window);
		now = $urandom;
		base = USER_W'($urandom_range(0, 65535));
		for (int n = 0; n < count; n++) begin
			// A few timestamps step backward to exercise the wrapped age.
			if ($urandom_range(0, 99) < 4)
				now = now - $urandom_range(1, 1000);
			else
				now = now + $urandom_range(0, step_max);
			send_request(USER_W'(base + $urandom_range(0, users - 1)), now);
		end
	endtask

	initial begin
		decisions = new();
		decisions.clear();
		idle_cycles = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= plsw_pkg::REG_MAX_REQUESTS;
		cfg_data <= '0;
		req.valid <= 1'b0;
		req.user_id <= '0;
		req.request_time <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset limits: three per user, window of ten.
		send_request(16'h0000, 32'd0);
		send_request(16'h0000, 32'd0);
		send_request(16'h0000, 32'd9);
		send_request(16'h0000, 32'd9);
		send_request(16'hFFFF, 32'd9);
		send_request(16'h0000, 32'd10);
		send_request(16'h0000, 32'd19);
		// Backward step: newer entries look ancient and expire.
		send_request(16'h0000, 32'd5);
		send_request(16'hFFFF, 32'hFFFF_FFFF);
		// Forward across the wrap: age of four stays live.
		send_request(16'hFFFF, 32'd3);
		wait_quiet();
		set_limits(7'd0, 32'd0);
		send_request(16'h1234, 32'd100);
		send_request(16'hAAAA, 32'd100);
		wait_quiet();
		set_limits(7'd1, 32'd0);
		send_request(16'h5555, 32'd100);
		send_request(16'h5555, 32'd100);

		run_phase(7'd3, 32'd10, 4, 4, 122);
		run_phase(7'd1, 32'd1, 3, 1, 122);
		run_phase(7'd64, 32'hFFFF_FFFF, 1, 3, 122);
		run_phase(7'd127, 32'hFFFF_FFFF, 80, 50, 122);
		run_phase(7'd0, $urandom_range(1, 1000), 4, 20, 122);
		run_phase(7'd2, 32'd100, 8, 10, 122);
		run_phase(7'd5, 32'd1000, 16, 100, 122);
		run_phase(COUNT_W'($urandom_range(1, 8)), $urandom_range(1, 500), 6, 40, 122);
		run_phase(7'd127, 32'd0, 5, 3, 122);
		run_phase(7'd64, 32'd2000, 2, 30, 122);
		run_phase(COUNT_W'($urandom_range(0, 127)), $urandom, 65536, $urandom, 122);

		wait_quiet();
		if (decisions.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
